// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the timer table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TT_ASSERT(lbl, clk, rst, prop, msg)
`define TT_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tt_pkg.sv -----
// Types and constants of the timer table.
package tt_pkg;
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCNT_W = $clog2(SLOTS + 1);
  localparam int QI_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int QCNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_ONESHOT  = 2'd0;
  localparam logic [1:0] CMD_PERIODIC = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_CAN   = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] expiry;
    logic [31:0] interval;
    logic        periodic;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;
endpackage

// ----- rtl/tt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/timer_table_one_shot_periodic.sv -----
// Timer table top level: command sequencer around the slot memory.
// Each command is a transfer taken when start is high and busy is low. The results of a
// command leave on the result ports, one per cycle while strobe is high. The receiver
// cannot stall, so each result must be taken in the cycle in which it appears. Every
// command walks the slot memory one slot a cycle. A pass is a scan of the slots followed
// by the decision step. Register and cancel take one pass, and their reply is on the
// ports in the first cycle with busy low. A tick that fires F timers runs F+1 passes
// (F passes when F reaches 16), one per fired timer in ascending id order. It then
// emits F results, or one "nothing fired" result, one per cycle, and the last of them
// is on the ports in the first cycle with busy low.
`include "assert_macros.svh"
module timer_table_one_shot_periodic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] delay_ms,
  input  logic [31:0] timer_id,
  output logic        strobe,
  output logic [1:0]  result_kind,
  output logic [1:0]  status,
  output logic [31:0] timer_id_res,
  output logic [4:0]  active_count,
  output logic        last
);
  import tt_pkg::*;

  state_t state;
  logic [1:0]  cmd;
  logic [31:0] arg_delay, arg_id;
  logic [63:0] now_ms;
  logic [31:0] next_id;
  logic [SLOTS-1:0] valid, fired;
  logic [SCNT_W-1:0] live, live_next;

  logic [SCNT_W-1:0] scan_i;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx, raddr;
  entry_t            rd_data;

  logic              match_f, free_f, best_f;
  logic [IDX_W-1:0]  match_idx, free_idx, best_idx;
  logic [31:0]       best_id, best_int;
  logic              best_per;

  logic [31:0]       q [MAX_RESULTS];
  logic [QCNT_W-1:0] nfired, emit_k;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;

  logic [31:0] key_id;
  logic        hit, cand, scan_done;

  assign busy      = (state != S_IDLE);
  assign key_id    = (cmd == CMD_CANCEL) ? arg_id : next_id;
  assign raddr     = scan_i[IDX_W-1:0];
  assign scan_done = (scan_i == SCNT_W'(SLOTS)) && !rd_vld;
  assign hit  = rd_vld && valid[rd_idx] && (rd_data.id == key_id);
  assign cand = rd_vld && valid[rd_idx] && !fired[rd_idx] && (now_ms >= rd_data.expiry)
                && (!best_f || rd_data.id < best_id);

  tt_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Write-back of the decided slot; the next pass reads it no earlier than the next cycle.
  always_comb begin
    we        = 1'b0;
    waddr     = match_f ? match_idx : free_idx;
    wdata.id       = next_id;
    wdata.expiry   = now_ms + {32'd0, arg_delay};
    wdata.interval = arg_delay;
    wdata.periodic = (cmd == CMD_PERIODIC);
    live_next = live;
    if (state == S_DECIDE) begin
      case (cmd)
        CMD_ONESHOT, CMD_PERIODIC: begin
          we = match_f || free_f;
          if (!match_f && free_f) begin
            live_next = live + SCNT_W'(1);
          end
        end
        CMD_CANCEL: begin
          if (match_f) begin
            live_next = live - SCNT_W'(1);
          end
        end
        default: begin
          waddr          = best_idx;
          wdata.id       = best_id;
          wdata.expiry   = now_ms + {32'd0, best_int};
          wdata.interval = best_int;
          wdata.periodic = best_per;
          if (best_f && nfired != QCNT_W'(MAX_RESULTS)) begin
            we = best_per;
            if (!best_per) begin
              live_next = live - SCNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      now_ms  <= 64'd0;
      next_id <= 32'd1;
      valid   <= '0;
      live    <= '0;
      strobe  <= 1'b0;
      rd_vld  <= 1'b0;
      nfired  <= '0;
    end else begin
      strobe <= 1'b0;
      live   <= live_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd       <= command;
            arg_delay <= delay_ms;
            arg_id    <= timer_id;
            if (command == CMD_TICK) begin
              now_ms <= now_ms + 64'd1;
            end
            scan_i  <= '0;
            rd_vld  <= 1'b0;
            match_f <= 1'b0;
            free_f  <= 1'b0;
            best_f  <= 1'b0;
            fired   <= '0;
            nfired  <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_i != SCNT_W'(SLOTS)) begin
            rd_vld <= 1'b1;
            rd_idx <= raddr;
            scan_i <= scan_i + SCNT_W'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (hit && !match_f) begin
            match_f   <= 1'b1;
            match_idx <= rd_idx;
          end
          if (rd_vld && !valid[rd_idx] && !free_f) begin
            free_f   <= 1'b1;
            free_idx <= rd_idx;
          end
          if (cand) begin
            best_f   <= 1'b1;
            best_idx <= rd_idx;
            best_id  <= rd_data.id;
            best_int <= rd_data.interval;
            best_per <= rd_data.periodic;
          end
          if (scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (cmd)
            CMD_ONESHOT, CMD_PERIODIC: begin
              strobe       <= 1'b1;
              result_kind  <= KIND_REG;
              last         <= 1'b1;
              active_count <= 5'(live_next);
              if (match_f || free_f) begin
                valid[waddr] <= 1'b1;
                next_id      <= next_id + 32'd1;
                status       <= ST_OK;
                timer_id_res <= next_id;
              end else begin
                status       <= ST_FULL;
                timer_id_res <= 32'd0;
              end
              state <= S_IDLE;
            end
            CMD_CANCEL: begin
              strobe       <= 1'b1;
              result_kind  <= KIND_CAN;
              last         <= 1'b1;
              active_count <= 5'(live_next);
              timer_id_res <= arg_id;
              status       <= match_f ? ST_OK : ST_NOTFOUND;
              if (match_f) begin
                valid[match_idx] <= 1'b0;
              end
              state <= S_IDLE;
            end
            default: begin
              emit_k <= '0;
              if (best_f && nfired != QCNT_W'(MAX_RESULTS)) begin
                fired[best_idx]       <= 1'b1;
                q[nfired[QI_W-1:0]]   <= best_id;
                nfired                <= nfired + QCNT_W'(1);
                if (!best_per) begin
                  valid[best_idx] <= 1'b0;
                end
                if (nfired + QCNT_W'(1) == QCNT_W'(MAX_RESULTS)) begin
                  state <= S_EMIT;
                end else begin
                  scan_i <= '0;
                  best_f <= 1'b0;
                  state  <= S_SCAN;
                end
              end else begin
                state <= S_EMIT;
              end
            end
          endcase
        end
        S_EMIT: begin
          strobe       <= 1'b1;
          status       <= ST_OK;
          active_count <= 5'(live);
          if (nfired == '0) begin
            result_kind  <= KIND_NONE;
            timer_id_res <= 32'd0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            result_kind  <= KIND_FIRED;
            timer_id_res <= q[emit_k[QI_W-1:0]];
            last         <= (emit_k + QCNT_W'(1) == nfired);
            emit_k       <= emit_k + QCNT_W'(1);
            if (emit_k + QCNT_W'(1) == nfired) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TT_ASSERT(a_strobe_after_busy, clk, rst, strobe |-> $past(busy), "result without a command")
  `TT_ASSERT(a_live_bound, clk, rst, live <= SCNT_W'(SLOTS), "live count above slot count")
  `TT_ASSERT(a_live_matches, clk, rst, (state == S_IDLE) |-> ($countones(valid) == int'(live)), "live count out of step with valid bits")
  `TT_ASSERT(a_fired_bound, clk, rst, nfired <= QCNT_W'(MAX_RESULTS), "too many fired timers")
  `TT_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy, "accepted command did not raise busy")
endmodule
